@@ sv/lmrs_pkg.sv @@
// ============================================================================
// LED matrix row serializer package
// Shared widths, event and operation codes, and the command record that
// travels from the front end to the shift engine.
// ============================================================================
package lmrs_pkg;

  // Default configuration
  localparam int unsigned PIXELS_PER_ROW_DEF = 8;
  localparam int unsigned ROWS_DEF           = 8;
  localparam int unsigned QUEUE_DEPTH_DEF    = 2;

  // Fixed field widths
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned ROW_W      = 3;
  localparam int unsigned MASK_W     = 8;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned PIXEL_BITS = 3 * COLOR_W;
  localparam int unsigned BIT_CNT_W  = $clog2(PIXEL_BITS);

  // Request operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_OFF   = 1'b1;

  // Result event codes
  localparam logic [KIND_W-1:0] EV_SHIFT = 2'd0;
  localparam logic [KIND_W-1:0] EV_LATCH = 2'd1;
  localparam logic [KIND_W-1:0] EV_MASK  = 2'd2;

  // Classified request, as queued between front end and shift engine
  typedef struct packed {
    logic                  is_off;
    logic                  ends_row;
    logic                  set_row;
    logic [ROW_W-1:0]      row;
    logic [PIXEL_BITS-1:0] bits;   // blue, green, red; MSB goes out first
  } cmd_t;

endpackage

@@ sv/lmrs_fifo.sv @@
// ============================================================================
// LED matrix row serializer command queue
// Small flop-based FIFO that decouples request intake from the shift engine.
// ============================================================================
module lmrs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = lmrs_pkg::QUEUE_DEPTH_DEF  // 2 and up
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_wr   = push_i && !full_o;
  assign do_rd   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    if (do_wr && !do_rd) begin
      count_d = CNT_W'(count_q + 1'b1);
    end else if (do_rd && !do_wr) begin
      count_d = CNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue fill count above depth");

endmodule

@@ sv/lmrs_front.sv @@
// ============================================================================
// LED matrix row serializer front end
// Classifies each accepted request and tracks the pixel position in the row.
// ============================================================================
module lmrs_front #(
  parameter int unsigned PIXELS_PER_ROW = lmrs_pkg::PIXELS_PER_ROW_DEF,
  parameter int unsigned ROWS           = lmrs_pkg::ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         operation_i,
  input  logic [lmrs_pkg::COLOR_W-1:0] red_i,
  input  logic [lmrs_pkg::COLOR_W-1:0] green_i,
  input  logic [lmrs_pkg::COLOR_W-1:0] blue_i,
  input  logic [lmrs_pkg::ROW_W-1:0]   row_index_i,
  output lmrs_pkg::cmd_t               cmd_o
);

  localparam int unsigned PIX_W = (PIXELS_PER_ROW > 1) ? $clog2(PIXELS_PER_ROW) : 1;

  logic [PIX_W-1:0] pix_cnt_q, pix_cnt_d;
  logic             ends_row;

  assign ends_row = (pix_cnt_q == PIX_W'(PIXELS_PER_ROW - 1));

  always_comb begin
    cmd_o.is_off   = (operation_i == lmrs_pkg::OP_OFF);
    cmd_o.ends_row = ends_row;
    // rows past the configured count still latch, but set no enable
    cmd_o.set_row  = (32'(row_index_i) < ROWS);
    cmd_o.row      = row_index_i;
    cmd_o.bits     = {blue_i, green_i, red_i};
  end

  always_comb begin
    pix_cnt_d = pix_cnt_q;
    // off command leaves the row position alone
    if (accept_i && operation_i == lmrs_pkg::OP_PIXEL) begin
      pix_cnt_d = ends_row ? '0 : PIX_W'(pix_cnt_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_cnt_q <= '0;
    end else begin
      pix_cnt_q <= pix_cnt_d;
    end
  end

  a_pix_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pix_cnt_q) < PIXELS_PER_ROW)
    else $error("pixel position past end of row");

endmodule

@@ sv/lmrs_back.sv @@
// ============================================================================
// LED matrix row serializer shift engine
// Turns queued requests into shift, latch and mask events, one per cycle
// while the output is drained, and keeps the row enable mask.
// ============================================================================
module lmrs_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lmrs_pkg::cmd_t              cmd_i,
  input  logic                        cmd_vld_i,
  output logic                        cmd_take_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [lmrs_pkg::KIND_W-1:0] event_kind_o,
  output logic                        data_bit_o,
  output logic [lmrs_pkg::MASK_W-1:0] row_enables_o,
  output logic                        last_o
);

  localparam int unsigned PB    = lmrs_pkg::PIXEL_BITS;
  localparam int unsigned CW    = lmrs_pkg::BIT_CNT_W;
  localparam int unsigned MW    = lmrs_pkg::MASK_W;
  localparam int unsigned KW    = lmrs_pkg::KIND_W;
  localparam int unsigned RW    = lmrs_pkg::ROW_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_LATCH = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [PB-1:0] shift_q, shift_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ends_q, ends_d;
  logic          set_q, set_d;
  logic [RW-1:0] row_q, row_d;
  logic [MW-1:0] mask_q, mask_d;

  logic          out_vld_q;
  logic [KW-1:0] kind_q;
  logic          bit_q;
  logic [MW-1:0] ren_q;
  logic          last_q;

  logic          adv, emit;
  logic [KW-1:0] ev_kind;
  logic          ev_bit, ev_last;

  // output stage takes a new event when empty or being drained
  assign adv = !out_vld_q || pop_i;

  always_comb begin
    state_d    = state_q;
    shift_d    = shift_q;
    cnt_d      = cnt_q;
    ends_d     = ends_q;
    set_d      = set_q;
    row_d      = row_q;
    mask_d     = mask_q;
    cmd_take_o = 1'b0;
    emit       = 1'b0;
    ev_kind    = lmrs_pkg::EV_SHIFT;
    ev_bit     = 1'b0;
    ev_last    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        // first event of a request leaves straight from the queue head
        if (adv && cmd_vld_i) begin
          cmd_take_o = 1'b1;
          emit       = 1'b1;
          if (cmd_i.is_off) begin
            mask_d  = '0;
            ev_kind = lmrs_pkg::EV_MASK;
            ev_last = 1'b1;
          end else begin
            ev_bit  = cmd_i.bits[PB-1];
            shift_d = cmd_i.bits << 1;
            cnt_d   = CW'(1);
            ends_d  = cmd_i.ends_row;
            set_d   = cmd_i.set_row;
            row_d   = cmd_i.row;
            state_d = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        if (adv) begin
          emit    = 1'b1;
          ev_bit  = shift_q[PB-1];
          shift_d = shift_q << 1;
          cnt_d   = CW'(cnt_q + 1'b1);
          if (cnt_q == CW'(PB - 1)) begin
            ev_last = !ends_q;
            state_d = ends_q ? ST_LATCH : ST_IDLE;
          end
        end
      end
      ST_LATCH: begin
        if (adv) begin
          emit    = 1'b1;
          ev_kind = lmrs_pkg::EV_LATCH;
          ev_last = 1'b1;
          if (set_q) begin
            mask_d = mask_q | (MW'(1) << row_q);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mask_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mask_q  <= mask_d;
      if (adv) begin
        out_vld_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    cnt_q   <= cnt_d;
    ends_q  <= ends_d;
    set_q   <= set_d;
    row_q   <= row_d;
    if (adv && emit) begin
      kind_q <= ev_kind;
      bit_q  <= ev_bit;
      ren_q  <= mask_d;
      last_q <= ev_last;
    end
  end

  assign empty_o       = !out_vld_q;
  assign event_kind_o  = kind_q;
  assign data_bit_o    = bit_q;
  assign row_enables_o = ren_q;
  assign last_o        = last_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SHIFT |-> (cnt_q != '0 && cnt_q <= CW'(PB - 1)))
    else $error("bit counter out of range while shifting");

  a_latch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && kind_q != lmrs_pkg::EV_SHIFT |-> last_q && !bit_q)
    else $error("latch or mask event not closing its request");

  a_off_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && kind_q == lmrs_pkg::EV_MASK |-> ren_q == '0)
    else $error("off command left rows enabled");

  a_latch_after_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LATCH |-> $past(state_q) == ST_SHIFT || $past(state_q) == ST_LATCH)
    else $error("latch phase entered without shifting a pixel");

endmodule

@@ sv/led_matrix_row_serializer.sv @@
// ============================================================================
// LED matrix row serializer
// Serializes pixel requests into driver shift/latch events and keeps the
// row enable mask.
// ============================================================================
// Each request is a pixel or an all-rows-off command. A pixel produces 24
// shift events (blue, green, red, each MSB first), one per clock while pop
// keeps the output drained; the PIXELS_PER_ROW-th pixel of a row adds a
// latch event that first sets the pixel's row bit in the row mask (rows at or
// past ROWS latch without setting a bit). An off command clears the mask and
// produces a single mask event; the row position is kept. The single-bit
// shift engine emits one event per clock unless the output is stalled. The
// front end classifies a request and tracks the row position on the clock
// edge it is accepted; up to QUEUE_DEPTH classified requests wait in a queue
// ahead of the shift engine, so push keeps being taken while a pixel is still
// shifting, as long as the queue has room. Events leave through a one-entry
// output register: empty low shows an event, pop takes it, and with pop held
// high the engine runs without bubbles across request boundaries. Every
// event carries the row mask as it stands after the event; last marks the
// final event of each request. No clearing pass is needed after reset.
// ============================================================================
module led_matrix_row_serializer #(
  parameter int unsigned PIXELS_PER_ROW = lmrs_pkg::PIXELS_PER_ROW_DEF,  // 1..64
  parameter int unsigned ROWS           = lmrs_pkg::ROWS_DEF,            // 1..8
  parameter int unsigned QUEUE_DEPTH    = lmrs_pkg::QUEUE_DEPTH_DEF      // 2 and up
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request side
  input  logic                          push,
  output logic                          full,
  input  logic                          operation_i,
  input  logic [lmrs_pkg::COLOR_W-1:0]  red_i,
  input  logic [lmrs_pkg::COLOR_W-1:0]  green_i,
  input  logic [lmrs_pkg::COLOR_W-1:0]  blue_i,
  input  logic [lmrs_pkg::ROW_W-1:0]    row_index_i,
  // event side
  output logic                          empty,
  input  logic                          pop,
  output logic [lmrs_pkg::KIND_W-1:0]   event_kind_o,
  output logic                          data_bit_o,
  output logic [lmrs_pkg::MASK_W-1:0]   row_enables_o,
  output logic                          last_o
);

  lmrs_pkg::cmd_t front_cmd;
  lmrs_pkg::cmd_t queue_cmd;
  logic           accept;
  logic           queue_empty;
  logic           engine_take;

  // a request is taken whenever the queue has room
  assign accept = push && !full;

  lmrs_front #(
    .PIXELS_PER_ROW (PIXELS_PER_ROW),
    .ROWS           (ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .operation_i (operation_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .row_index_i (row_index_i),
    .cmd_o       (front_cmd)
  );

  // classified requests wait here while the engine is shifting
  lmrs_fifo #(
    .WIDTH ($bits(lmrs_pkg::cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (engine_take),
    .data_o  (queue_cmd),
    .empty_o (queue_empty)
  );

  lmrs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (queue_cmd),
    .cmd_vld_i     (!queue_empty),
    .cmd_take_o    (engine_take),
    .pop_i         (pop),
    .empty_o       (empty),
    .event_kind_o  (event_kind_o),
    .data_bit_o    (data_bit_o),
    .row_enables_o (row_enables_o),
    .last_o        (last_o)
  );

endmodule
